// ----- sv/pgcp_pkg.sv -----
// Package for the pose gated contour projection block.
// Holds widths, payload types, reset constants and the rounding helpers.
// No dependencies.
package pgcp_pkg;

  localparam int COORD_W    = 32;
  localparam int COORD_FRAC = 16;
  localparam int QUAT_W     = 16;
  localparam int QUAT_FRAC  = QUAT_W - 2;
  localparam int ROT_W      = QUAT_W + 2;
  localparam int THR_W      = 31;
  localparam int QPROD_W    = 2 * QUAT_W;
  localparam int ENT_W      = QPROD_W + 4;
  localparam int PROD_W     = COORD_W + ROT_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int GSQ_W      = 2 * THR_W;
  localparam int GSUM_W     = GSQ_W + 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [ROT_W-1:0]   rot_t;
  typedef logic        [THR_W-1:0]   thr_t;
  typedef logic signed [QPROD_W-1:0] qprod_t;
  typedef logic signed [ENT_W-1:0]   ent_t;

  localparam thr_t   THR_RESET = thr_t'(52429);
  localparam coord_t POS_RESET = coord_t'(5000 * (1 << COORD_FRAC));
  localparam ent_t   ENT_ONE   = ent_t'(1) <<< (2 * QUAT_FRAC);

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pt_t;

  typedef struct packed {
    rot_t   [5:0] rot;
    coord_t [2:0] trans;
  } xform_t;

  function automatic rot_t rot_round(input ent_t full);
    ent_t r;
    ent_t hi;
    ent_t lo;
    r  = (full + (ent_t'(1) <<< (QUAT_FRAC - 1))) >>> QUAT_FRAC;
    hi = (ent_t'(1) <<< (ROT_W - 1)) - ent_t'(1);
    lo = -hi - ent_t'(1);
    if (r > hi) begin
      return rot_t'(hi);
    end else if (r < lo) begin
      return rot_t'(lo);
    end
    return rot_t'(r);
  endfunction

  function automatic coord_t sat_coord(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (ACC_W'(1) <<< (COORD_W - 1)) - ACC_W'(1);
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      return coord_t'(hi);
    end else if (v < lo) begin
      return coord_t'(lo);
    end
    return coord_t'(v);
  endfunction

endpackage

// ----- sv/pgcp_in_if.sv -----
// Input channel of the contour projection block: one contour point with pose.
// Depends on pgcp_pkg.
interface pgcp_in_if import pgcp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  quat_t  quat_w;
  quat_t  quat_x;
  quat_t  quat_y;
  quat_t  quat_z;
  logic   first_of_frame;
  logic   last_of_frame;

  modport source (output valid, point_x, point_y, pos_x, pos_y, pos_z, quat_w, quat_x,
                  quat_y, quat_z, first_of_frame, last_of_frame, input ready);
  modport sink (input valid, point_x, point_y, pos_x, pos_y, pos_z, quat_w, quat_x,
                quat_y, quat_z, first_of_frame, last_of_frame, output ready);
endinterface

// ----- sv/pgcp_out_if.sv -----
// Result channel of the contour projection block: one projected world point.
// Depends on pgcp_pkg.
interface pgcp_out_if import pgcp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t world_x;
  coord_t world_y;
  coord_t world_z;
  logic   frame_end;

  modport source (output valid, world_x, world_y, world_z, frame_end, input ready);
  modport sink (input valid, world_x, world_y, world_z, frame_end, output ready);
endinterface

// ----- sv/pose_gated_contour_projection.sv -----
// Top level of the pose gated contour projection block.
// Depends on pgcp_pkg, pgcp_in_if, pgcp_out_if, pgcp_front, pgcp_fifo, pgcp_back.
//
// Usage:
//   in_ch carries contour points with the sensor pose (valid/ready). Points are
//   grouped into frames by first_of_frame / last_of_frame. On a frame's first
//   point the pose is compared to the last accepted position; a frame that moved
//   more than cfg move threshold is projected, any other frame is dropped whole.
//   out_ch carries one world point per point of an accepted frame (valid/ready).
//   cfg_we / cfg_wdata write the movement threshold; write only while idle.
// Flow:
//   A non-first point is queued as it is taken if its frame was accepted. A first
//   point blocks the input during gate and rotation build (one shared 31x31
//   squarer, one 16x16 multiplier); an accepted frame then waits for the back end
//   to drain the previous frame. Projection runs one axis per step on two shared
//   32x18 multipliers; a new point is taken as the last one leaves for the output.
// Reset: rst_n is synchronous, active low; last accepted position returns to
//   5000.0 on each axis, threshold to 0.8, no frame open.
// Stall: the output register holds a result until taken; the 4-entry queue
//   fills and then in_ch.ready drops.
module pose_gated_contour_projection import pgcp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pgcp_in_if.sink    in_ch,
  pgcp_out_if.source out_ch,
  input  logic cfg_we,
  input  thr_t cfg_wdata
);

  logic   push;
  pt_t    push_data;
  logic   pop;
  pt_t    head;
  logic   fifo_full;
  logic   fifo_empty;
  logic   back_busy;
  xform_t xform;

  pgcp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fifo_full  (fifo_full),
    .fifo_empty (fifo_empty),
    .back_busy  (back_busy),
    .push       (push),
    .push_data  (push_data),
    .xform      (xform)
  );

  pgcp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  pgcp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .xform      (xform),
    .busy       (back_busy),
    .out_ch     (out_ch)
  );

endmodule

// ----- sv/pgcp_fifo.sv -----
// Small point queue between the gating front end and the projection back end.
// Depends on pgcp_pkg.
module pgcp_fifo import pgcp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  pt_t  push_data,
  input  logic pop,
  output pt_t  head,
  output logic full,
  output logic empty
);

  pt_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= push_data;
        wr_ptr_r        <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

// ----- sv/pgcp_front.sv -----
// Front end: accepts points, runs the movement gate on the first point of a frame,
// builds the rotation entries and queues points of accepted frames. Depends on pgcp_pkg.
module pgcp_front import pgcp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  pgcp_in_if.sink in_ch,
  input  logic   cfg_we,
  input  thr_t   cfg_wdata,
  input  logic   fifo_full,
  input  logic   fifo_empty,
  input  logic   back_busy,
  output logic   push,
  output pt_t    push_data,
  output xform_t xform
);

  typedef enum logic [1:0] {F_IDLE, F_CALC, F_WAIT} fstate_t;

  fstate_t             state_r;
  logic [3:0]          cnt_r;
  thr_t                thr_r;
  logic                frame_acc_r;
  logic                far_r;
  coord_t              lpos_r [3];
  coord_t              pos_r [3];
  quat_t               qw_r, qx_r, qy_r, qz_r;
  pt_t                 pt_r;
  logic [GSQ_W-1:0]    gprod_r;
  logic [GSUM_W-1:0]   gsum_r;
  qprod_t              rp_r [9];
  xform_t              xform_r;

  logic                acc;
  logic                drained;
  coord_t              dp, dl;
  logic signed [COORD_W:0] d;
  logic [COORD_W:0]    ad;
  logic                over;
  logic                in_gate;
  logic [THR_W-1:0]    op;
  quat_t               qa, qb;
  rot_t                ent [6];

  assign in_ch.ready = (state_r == F_IDLE) && !fifo_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign drained     = fifo_empty && !back_busy;
  assign xform       = xform_r;

  always_comb begin
    push      = 1'b0;
    push_data = '{x: in_ch.point_x, y: in_ch.point_y, last: in_ch.last_of_frame};
    if (state_r == F_WAIT) begin
      push      = drained;
      push_data = pt_r;
    end else if (state_r == F_IDLE) begin
      push = acc && !in_ch.first_of_frame && frame_acc_r;
    end
  end

  always_comb begin
    case (cnt_r)
      4'd0: begin dp = pos_r[0]; dl = lpos_r[0]; end
      4'd1: begin dp = pos_r[1]; dl = lpos_r[1]; end
      4'd2: begin dp = pos_r[2]; dl = lpos_r[2]; end
      default: begin dp = '0; dl = '0; end
    endcase
    d       = (COORD_W+1)'(dp) - (COORD_W+1)'(dl);
    ad      = d[COORD_W] ? (COORD_W+1)'(-d) : (COORD_W+1)'(d);
    over    = ad > {2'b00, thr_r};
    in_gate = cnt_r < 4'd3;
    if (in_gate) begin
      op = over ? '0 : ad[THR_W-1:0];
    end else if (cnt_r == 4'd3) begin
      op = thr_r;
    end else begin
      op = '0;
    end
  end

  // product order: yy zz xy zw xz yw xx yz xw
  always_comb begin
    case (cnt_r)
      4'd0: begin qa = qy_r; qb = qy_r; end
      4'd1: begin qa = qz_r; qb = qz_r; end
      4'd2: begin qa = qx_r; qb = qy_r; end
      4'd3: begin qa = qz_r; qb = qw_r; end
      4'd4: begin qa = qx_r; qb = qz_r; end
      4'd5: begin qa = qy_r; qb = qw_r; end
      4'd6: begin qa = qx_r; qb = qx_r; end
      4'd7: begin qa = qy_r; qb = qz_r; end
      4'd8: begin qa = qx_r; qb = qw_r; end
      default: begin qa = '0; qb = '0; end
    endcase
  end

  always_comb begin
    ent[0] = rot_round(ENT_ONE - ent_t'(2) * (ent_t'(rp_r[0]) + ent_t'(rp_r[1])));
    ent[1] = rot_round(ent_t'(2) * (ent_t'(rp_r[2]) + ent_t'(rp_r[3])));
    ent[2] = rot_round(ent_t'(2) * (ent_t'(rp_r[4]) - ent_t'(rp_r[5])));
    ent[3] = rot_round(ent_t'(2) * (ent_t'(rp_r[2]) - ent_t'(rp_r[3])));
    ent[4] = rot_round(ENT_ONE - ent_t'(2) * (ent_t'(rp_r[6]) + ent_t'(rp_r[1])));
    ent[5] = rot_round(ent_t'(2) * (ent_t'(rp_r[7]) + ent_t'(rp_r[8])));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      cnt_r       <= '0;
      thr_r       <= THR_RESET;
      frame_acc_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lpos_r[i] <= POS_RESET;
      end
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      case (state_r)
        F_IDLE: begin
          if (acc) begin
            if (in_ch.first_of_frame) begin
              pos_r[0] <= in_ch.pos_x;
              pos_r[1] <= in_ch.pos_y;
              pos_r[2] <= in_ch.pos_z;
              qw_r     <= in_ch.quat_w;
              qx_r     <= in_ch.quat_x;
              qy_r     <= in_ch.quat_y;
              qz_r     <= in_ch.quat_z;
              pt_r     <= '{x: in_ch.point_x, y: in_ch.point_y, last: in_ch.last_of_frame};
              far_r    <= 1'b0;
              gsum_r   <= '0;
              cnt_r    <= '0;
              state_r  <= F_CALC;
            end else if (in_ch.last_of_frame) begin
              frame_acc_r <= 1'b0;
            end
          end
        end
        F_CALC: begin
          gprod_r <= GSQ_W'(op) * GSQ_W'(op);
          if (in_gate && over) begin
            far_r <= 1'b1;
          end
          if (cnt_r >= 4'd1 && cnt_r <= 4'd3) begin
            gsum_r <= gsum_r + GSUM_W'(gprod_r);
          end
          if (cnt_r == 4'd4 && gsum_r > GSUM_W'(gprod_r)) begin
            far_r <= 1'b1;
          end
          if (cnt_r < 4'd9) begin
            rp_r[cnt_r] <= QPROD_W'(qa) * QPROD_W'(qb);
            cnt_r       <= cnt_r + 4'd1;
          end else if (far_r) begin
            state_r <= F_WAIT;
          end else begin
            frame_acc_r <= 1'b0;
            state_r     <= F_IDLE;
          end
        end
        F_WAIT: begin
          if (drained) begin
            for (int i = 0; i < 6; i++) begin
              xform_r.rot[i] <= ent[i];
            end
            for (int i = 0; i < 3; i++) begin
              xform_r.trans[i] <= pos_r[i];
              lpos_r[i]        <= pos_r[i];
            end
            frame_acc_r <= !pt_r.last;
            state_r     <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/pgcp_back.sv -----
// Back end: rotates, translates queued points on two shared multipliers, one axis per
// cycle unless out_ch stalls; an output register holds results. Depends on pgcp_pkg.
module pgcp_back import pgcp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  pt_t    head,
  input  logic   fifo_empty,
  output logic   pop,
  input  xform_t xform,
  output logic   busy,
  pgcp_out_if.source out_ch
);

  logic                     busy_r;
  logic [1:0]               step_r;
  coord_t                   x_r, y_r;
  logic                     last_r;
  logic signed [PROD_W-1:0] pa_r, pb_r;
  coord_t                   res0_r, res1_r;
  logic                     out_valid_r;
  coord_t                   out_x_r, out_y_r, out_z_r;
  logic                     out_last_r;

  rot_t                     ra, rb;
  coord_t                   tr;
  logic signed [ACC_W-1:0]  acc_sum;
  coord_t                   proj;
  logic                     slot_free;
  logic                     fin;

  assign busy              = busy_r;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.world_x    = out_x_r;
  assign out_ch.world_y    = out_y_r;
  assign out_ch.world_z    = out_z_r;
  assign out_ch.frame_end  = out_last_r;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign fin       = busy_r && (step_r == 2'd3) && slot_free;
  assign pop       = !fifo_empty && (!busy_r || fin);

  always_comb begin
    case (step_r)
      2'd0: begin ra = xform.rot[0]; rb = xform.rot[3]; end
      2'd1: begin ra = xform.rot[1]; rb = xform.rot[4]; end
      2'd2: begin ra = xform.rot[2]; rb = xform.rot[5]; end
      default: begin ra = '0; rb = '0; end
    endcase
    case (step_r)
      2'd1: tr = xform.trans[0];
      2'd2: tr = xform.trans[1];
      2'd3: tr = xform.trans[2];
      default: tr = '0;
    endcase
    acc_sum = (ACC_W'(pa_r) + ACC_W'(pb_r) + (ACC_W'(1) <<< (QUAT_FRAC - 1))) >>> QUAT_FRAC;
    proj    = sat_coord(acc_sum + ACC_W'(tr));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (busy_r && step_r != 2'd3) begin
        pa_r <= PROD_W'(x_r) * PROD_W'(ra);
        pb_r <= PROD_W'(y_r) * PROD_W'(rb);
      end
      if (busy_r && step_r == 2'd1) begin
        res0_r <= proj;
      end
      if (busy_r && step_r == 2'd2) begin
        res1_r <= proj;
      end
      if (pop) begin
        x_r    <= head.x;
        y_r    <= head.y;
        last_r <= head.last;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (fin) begin
        busy_r <= 1'b0;
      end else if (busy_r && step_r != 2'd3) begin
        step_r <= step_r + 2'd1;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
        out_x_r     <= res0_r;
        out_y_r     <= res1_r;
        out_z_r     <= proj;
        out_last_r  <= last_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
